// ----- rtl/go_back_n_sender_defines.svh -----
// Assertion helpers for the RTL, included by gbn_back.sv.
`ifndef GO_BACK_N_SENDER_DEFINES_SVH
`define GO_BACK_N_SENDER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define GBN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GBN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/gbn_pkg.sv -----
`timescale 1ns / 1ps
package gbn_pkg;

  localparam int PAYLOAD_BYTES = 20;
  localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;
  localparam int BUF_DEPTH     = 64;
  localparam int BUF_AW        = 6;
  localparam int MAX_WINDOW    = 16;
  localparam int BSUM_W        = 13;
  localparam int ENTRY_W       = BSUM_W + PAYLOAD_W;

  localparam logic [7:0] CHAR_ZERO = 8'd48;

  localparam logic [1:0] REQ_MSG = 2'd0;
  localparam logic [1:0] REQ_ACK = 2'd1;
  localparam logic [1:0] REQ_TMO = 2'd2;

  localparam logic [1:0] TMR_NONE    = 2'd0;
  localparam logic [1:0] TMR_START   = 2'd1;
  localparam logic [1:0] TMR_STOP    = 2'd2;
  localparam logic [1:0] TMR_RESTART = 2'd3;

  typedef struct packed {
    logic [1:0]           kind;
    logic [PAYLOAD_W-1:0] payload;
    logic [BSUM_W-1:0]    bsum;
    logic [31:0]          acknum;
    logic                 ack_ok;
  } gbn_item_t;

endpackage

// ----- rtl/gbn_front.sv -----
`timescale 1ns / 1ps
module gbn_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    req_type,
  input  logic [63:0]                   payload_w0,
  input  logic [63:0]                   payload_w1,
  input  logic [31:0]                   payload_w2,
  input  logic signed [31:0]            pkt_seqnum,
  input  logic signed [31:0]            pkt_acknum,
  input  logic signed [31:0]            pkt_checksum,
  input  logic                          q_full,
  output logic                          push,
  output gbn_pkg::gbn_item_t            item
);

  logic                          in_vld;
  logic [1:0]                    kind;
  logic [gbn_pkg::PAYLOAD_W-1:0] raw;
  logic [31:0]                   seqnum;
  logic [31:0]                   acknum;
  logic [31:0]                   csum;
  logic                          accept;

  logic [gbn_pkg::PAYLOAD_W-1:0] clean;
  logic [gbn_pkg::BSUM_W-1:0]    term [gbn_pkg::PAYLOAD_BYTES];
  logic [gbn_pkg::BSUM_W-1:0]    grp [5];
  logic [gbn_pkg::BSUM_W-1:0]    bsum;
  logic [31:0]                   total;

  assign busy   = in_vld & q_full;
  assign accept = start & ~busy;
  assign push   = in_vld & ~q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= accept | busy;
    end
    if (accept) begin
      kind   <= req_type;
      raw    <= {payload_w2, payload_w1, payload_w0};
      seqnum <= pkt_seqnum;
      acknum <= pkt_acknum;
      csum   <= pkt_checksum;
    end
  end

  // Every byte from the first NUL onward reads as zero.
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < gbn_pkg::PAYLOAD_BYTES; i++) begin
      if (raw[8*i +: 8] == 8'd0) seen = 1'b1;
      clean[8*i +: 8] = seen ? 8'd0 : raw[8*i +: 8];
      term[i] = {{(gbn_pkg::BSUM_W-8){clean[8*i+7]}}, clean[8*i +: 8]}
                - {{(gbn_pkg::BSUM_W-8){1'b0}}, gbn_pkg::CHAR_ZERO};
    end
  end

  always_comb begin
    for (int g = 0; g < 5; g++) begin
      grp[g] = (term[4*g] + term[4*g+1]) + (term[4*g+2] + term[4*g+3]);
    end
    bsum  = (grp[0] + grp[1]) + (grp[2] + grp[3]) + grp[4];
    total = seqnum + acknum + {{(32-gbn_pkg::BSUM_W){bsum[gbn_pkg::BSUM_W-1]}}, bsum};
  end

  always_comb begin
    item.kind    = kind;
    item.payload = clean;
    item.bsum    = bsum;
    item.acknum  = acknum;
    item.ack_ok  = (total == csum);
  end

endmodule

// ----- rtl/gbn_queue.sv -----
`timescale 1ns / 1ps
module gbn_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  gbn_pkg::gbn_item_t wdata,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output gbn_pkg::gbn_item_t rdata
);

  gbn_pkg::gbn_item_t slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign rdata = slot[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) slot[wptr] <= wdata;
  end

endmodule

// ----- rtl/gbn_back.sv -----
`timescale 1ns / 1ps
`include "go_back_n_sender_defines.svh"
module gbn_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [4:0]                    ew,
  input  logic                          q_valid,
  input  gbn_pkg::gbn_item_t            q_data,
  output logic                          pop,
  output logic                          out_strobe,
  output logic                          pkt_valid,
  output logic signed [31:0]            out_seqnum,
  output logic [gbn_pkg::PAYLOAD_W-1:0] out_payload,
  output logic signed [31:0]            out_checksum,
  output logic [1:0]                    timer_action,
  output logic                          msg_dropped,
  output logic                          ack_accepted,
  output logic                          last
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MSG  = 3'd1;
  localparam logic [2:0] S_ACK  = 3'd2;
  localparam logic [2:0] S_FCHK = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]                    state;
  logic                          mode_tmo;
  logic                          start_tmr;
  logic                          dropped;
  logic                          acc;
  logic [4:0]                    n;
  logic [4:0]                    outst;
  logic [31:0]                   base;
  logic [31:0]                   nseq;
  logic [gbn_pkg::BUF_AW-1:0]    head;
  logic [6:0]                    count;
  gbn_pkg::gbn_item_t            cur;
  logic [gbn_pkg::ENTRY_W-1:0]   mem [gbn_pkg::BUF_DEPTH];
  logic [gbn_pkg::ENTRY_W-1:0]   rdata;

  logic [31:0]                   diff;
  logic [4:0]                    freed;
  logic                          cond;
  logic                          more;
  logic [31:0]                   eseq;
  logic [1:0]                    etmr;
  logic [1:0]                    final_tmr;
  logic [gbn_pkg::BUF_AW-1:0]    raddr;
  logic [gbn_pkg::BSUM_W-1:0]    rbsum;

  assign pop   = (state == S_IDLE) && q_valid;
  assign diff  = cur.acknum - base;
  assign freed = diff[4:0] + 5'd1;
  assign raddr = head + {1'b0, (mode_tmo ? n : outst)};
  assign rbsum = rdata[gbn_pkg::ENTRY_W-1 -: gbn_pkg::BSUM_W];

  always_comb begin
    if (mode_tmo) begin
      cond = (n < outst);
      more = ({1'b0, n} + 6'd1) < {1'b0, outst};
      eseq = base + {27'd0, n};
      etmr = (n == 5'd0) ? gbn_pkg::TMR_START : gbn_pkg::TMR_NONE;
    end else begin
      cond = (outst < ew) && ({2'b0, outst} < count) && (n < 5'd16);
      more = (({1'b0, outst} + 6'd1) < {1'b0, ew}) && (({2'b0, outst} + 7'd1) < count)
             && (n < 5'd15);
      eseq = nseq;
      etmr = (start_tmr && outst == 5'd0) ? gbn_pkg::TMR_START : gbn_pkg::TMR_NONE;
    end
  end

  // Accepted acks override the timer code of the item's final beat; a timeout that sends nothing starts the timer.
  always_comb begin
    if (mode_tmo) begin
      final_tmr = gbn_pkg::TMR_START;
    end else if (acc) begin
      final_tmr = (outst == 5'd0) ? gbn_pkg::TMR_STOP : gbn_pkg::TMR_RESTART;
    end else begin
      final_tmr = gbn_pkg::TMR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MSG && !count[6]) begin
      mem[head + count[gbn_pkg::BUF_AW-1:0]] <= {cur.bsum, cur.payload};
    end
    if (state == S_FCHK) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mode_tmo   <= 1'b0;
      start_tmr  <= 1'b0;
      dropped    <= 1'b0;
      acc        <= 1'b0;
      n          <= 5'd0;
      outst      <= 5'd0;
      base       <= 32'd1;
      nseq       <= 32'd1;
      head       <= '0;
      count      <= 7'd0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe   <= 1'b0;
      pkt_valid    <= 1'b0;
      out_seqnum   <= '0;
      out_payload  <= '0;
      out_checksum <= '0;
      timer_action <= gbn_pkg::TMR_NONE;
      msg_dropped  <= 1'b0;
      ack_accepted <= 1'b0;
      last         <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur      <= q_data;
            dropped  <= 1'b0;
            acc      <= 1'b0;
            n        <= 5'd0;
            mode_tmo <= (q_data.kind == gbn_pkg::REQ_TMO);
            case (q_data.kind)
              gbn_pkg::REQ_MSG: state <= S_MSG;
              gbn_pkg::REQ_ACK: state <= S_ACK;
              gbn_pkg::REQ_TMO: state <= S_FCHK;
              default: begin
                out_strobe <= 1'b1;
                last       <= 1'b1;
              end
            endcase
          end
        end
        S_MSG: begin
          if (!count[6]) begin
            count <= count + 7'd1;
          end else begin
            dropped <= 1'b1;
          end
          start_tmr <= 1'b1;
          state     <= S_FCHK;
        end
        S_ACK: begin
          if (cur.ack_ok && diff < {27'd0, outst}) begin
            base      <= cur.acknum + 32'd1;
            head      <= head + {1'b0, freed};
            count     <= count - {2'b0, freed};
            outst     <= outst - freed;
            acc       <= 1'b1;
            start_tmr <= 1'b0;
            state     <= S_FCHK;
          end else begin
            out_strobe <= 1'b1;
            last       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_FCHK: begin
          if (cond) begin
            state <= S_EMIT;
          end else begin
            out_strobe   <= 1'b1;
            last         <= 1'b1;
            timer_action <= final_tmr;
            msg_dropped  <= dropped;
            ack_accepted <= acc;
            state        <= S_IDLE;
          end
        end
        S_EMIT: begin
          out_strobe   <= 1'b1;
          pkt_valid    <= 1'b1;
          out_seqnum   <= eseq;
          out_payload  <= rdata[gbn_pkg::PAYLOAD_W-1:0];
          out_checksum <= eseq + {{(32-gbn_pkg::BSUM_W){rbsum[gbn_pkg::BSUM_W-1]}}, rbsum};
          n            <= n + 5'd1;
          if (!mode_tmo) begin
            nseq  <= nseq + 32'd1;
            outst <= outst + 5'd1;
          end
          if (more) begin
            timer_action <= etmr;
            state        <= S_FCHK;
          end else begin
            last         <= 1'b1;
            msg_dropped  <= dropped;
            ack_accepted <= acc;
            timer_action <= acc ? gbn_pkg::TMR_RESTART : etmr;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GBN_ASSERT_NOW(a_outst_cap, 1'b1, outst <= 5'd16, "more than sixteen packets in flight")
  `GBN_ASSERT_NOW(a_outst_stored, 1'b1, {2'b0, outst} <= count, "in-flight packet not held")
  `GBN_ASSERT_NOW(a_last_idle, out_strobe && last, state == S_IDLE, "final beat left busy")

endmodule

// ----- rtl/go_back_n_sender.sv -----
`timescale 1ns / 1ps
// Go-Back-N sender.
// Pulse start with req_type and its fields while busy is low: a message to
// send, an arriving ack packet, or a timer expiry. Items enter an input
// register and a two-entry queue; a back end handles one item at a time.
// Each item gives one or more result beats on the out_* ports, each marked
// by out_strobe for exactly one cycle; last flags the item's final beat.
// A message is first written to the store, unless the store is full; then a
// store read and the first packet beat follow. An accepted ack is checked,
// then reads and sends the same way; a timeout starts at the store read.
// Each further packet takes another store read, then its beat, up to a full
// window of sixteen packets. An item that sends nothing gives a single beat.
// window_size is written with cfg_we and cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Reset sets it to 8, base and next sequence to 1, and empties the store.
// Results cannot be held off by the receiver.
module go_back_n_sender (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  input  logic [1:0]         req_type,
  input  logic [63:0]        payload_w0,
  input  logic [63:0]        payload_w1,
  input  logic [31:0]        payload_w2,
  input  logic signed [31:0] pkt_seqnum,
  input  logic signed [31:0] pkt_acknum,
  input  logic signed [31:0] pkt_checksum,
  output logic               out_strobe,
  output logic               pkt_valid,
  output logic signed [31:0] out_seqnum,
  output logic [63:0]        out_payload_w0,
  output logic [63:0]        out_payload_w1,
  output logic [31:0]        out_payload_w2,
  output logic signed [31:0] out_checksum,
  output logic [1:0]         timer_action,
  output logic               msg_dropped,
  output logic               ack_accepted,
  output logic               last
);

  logic [4:0]                    window_size;
  logic [4:0]                    ew;
  logic                          push;
  logic                          q_full;
  logic                          q_valid;
  logic                          pop;
  gbn_pkg::gbn_item_t            f_item;
  gbn_pkg::gbn_item_t            q_item;
  logic [gbn_pkg::PAYLOAD_W-1:0] out_payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= 5'd8;
    end else if (cfg_we) begin
      window_size <= cfg_wdata;
    end
  end

  always_comb begin
    if (window_size == 5'd0) begin
      ew = 5'd1;
    end else if (window_size > 5'(gbn_pkg::MAX_WINDOW)) begin
      ew = 5'(gbn_pkg::MAX_WINDOW);
    end else begin
      ew = window_size;
    end
  end

  gbn_front u_front (
    .clk, .rst, .start, .busy, .req_type,
    .payload_w0, .payload_w1, .payload_w2,
    .pkt_seqnum, .pkt_acknum, .pkt_checksum,
    .q_full, .push, .item(f_item)
  );

  gbn_queue u_queue (
    .clk, .rst, .push, .wdata(f_item), .full(q_full),
    .pop, .valid(q_valid), .rdata(q_item)
  );

  gbn_back u_back (
    .clk, .rst, .ew, .q_valid, .q_data(q_item), .pop,
    .out_strobe, .pkt_valid, .out_seqnum, .out_payload, .out_checksum,
    .timer_action, .msg_dropped, .ack_accepted, .last
  );

  assign out_payload_w0 = out_payload[63:0];
  assign out_payload_w1 = out_payload[127:64];
  assign out_payload_w2 = out_payload[159:128];

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic        pv;
    logic [31:0] seq;
    logic [63:0] w0;
    logic [63:0] w1;
    logic [31:0] w2;
    logic [31:0] cs;
    logic [1:0]  tmr;
    logic        drop;
    logic        acc;
    logic        fin;
  } beat_t;

  typedef struct {
    logic [1:0]   kind;
    logic [63:0]  w0;
    logic [63:0]  w1;
    logic [31:0]  w2;
    logic [31:0]  seq;
    logic [31:0]  ack;
    logic [31:0]  cs;
    bit           fix_cs;
    bit           has_exp;
    logic [1:0]   exp_tmr;
  } row_t;

  logic clk = 0, rst = 1, start = 0, cfg_we = 0;
  logic [4:0] cfg_wdata = 0;
  logic [1:0] req_type = 0;
  logic [63:0] payload_w0 = 0, payload_w1 = 0;
  logic [31:0] payload_w2 = 0;
  logic signed [31:0] pkt_seqnum = 0, pkt_acknum = 0, pkt_checksum = 0;
  logic busy, out_strobe, pkt_valid, msg_dropped, ack_accepted, last;
  logic signed [31:0] out_seqnum, out_checksum;
  logic [63:0] out_payload_w0, out_payload_w1;
  logic [31:0] out_payload_w2;
  logic [1:0] timer_action;

  go_back_n_sender uut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Shadow of the sender state.
  logic [4:0]                    win_reg = 5'd8;
  logic [31:0]                   base_seq = 1, next_seq = 1;
  logic [gbn_pkg::PAYLOAD_W-1:0] backlog [gbn_pkg::BUF_DEPTH];
  int unsigned                   head = 0, count = 0;
  beat_t                         pending [$];
  bit                            failed = 0;

  function automatic logic [gbn_pkg::PAYLOAD_W-1:0] clean(
      logic [gbn_pkg::PAYLOAD_W-1:0] p);
    logic [gbn_pkg::PAYLOAD_W-1:0] r;
    bit z;
    r = '0;
    z = 0;
    for (int i = 0; i < gbn_pkg::PAYLOAD_BYTES; i++) begin
      if (p[8*i +: 8] == 8'd0) z = 1;
      if (!z) r[8*i +: 8] = p[8*i +: 8];
    end
    return r;
  endfunction

  function automatic logic [31:0] csum(logic [31:0] s, logic [31:0] a,
                                       logic [gbn_pkg::PAYLOAD_W-1:0] p);
    logic [31:0] t;
    logic [7:0] b;
    t = s + a;
    for (int i = 0; i < gbn_pkg::PAYLOAD_BYTES; i++) begin
      b = p[8*i +: 8];
      t = t + {{24{b[7]}}, b} - {24'd0, gbn_pkg::CHAR_ZERO};
    end
    return t;
  endfunction

  function automatic beat_t pkt_beat(logic [31:0] s, logic [gbn_pkg::PAYLOAD_W-1:0] p,
                                     logic [1:0] tm);
    beat_t b;
    b = '{default: 0};
    b.pv = 1;
    b.seq = s;
    b.w0 = p[63:0];
    b.w1 = p[127:64];
    b.w2 = p[159:128];
    b.cs = csum(s, 32'd0, p);
    b.tmr = tm;
    return b;
  endfunction

  function automatic int unsigned eff_win();
    if (win_reg == 0) return 1;
    if (win_reg > gbn_pkg::MAX_WINDOW) return gbn_pkg::MAX_WINDOW;
    return win_reg;
  endfunction

  // Sends from the backlog while the window has room.
  function automatic void fill_window(ref beat_t q[$], input bit timed);
    logic [31:0] outst;
    forever begin
      outst = next_seq - base_seq;
      if (outst >= eff_win() || outst >= count || q.size() >= 16) break;
      q.push_back(pkt_beat(next_seq, backlog[(head + outst) % gbn_pkg::BUF_DEPTH],
                           (timed && outst == 0) ? gbn_pkg::TMR_START : gbn_pkg::TMR_NONE));
      next_seq++;
    end
  endfunction

  function automatic void predict_sender(logic [1:0] kind,
                                         logic [gbn_pkg::PAYLOAD_W-1:0] raw,
                                         logic [31:0] s, logic [31:0] a,
                                         logic [31:0] c, bit use_exp, logic [1:0] etm);
    beat_t q[$];
    beat_t e;
    logic [gbn_pkg::PAYLOAD_W-1:0] p;
    logic [31:0] outst, freed;
    bit drop;
    p = clean(raw);
    e = '{default: 0};
    outst = next_seq - base_seq;
    case (kind)
      gbn_pkg::REQ_MSG: begin
        drop = 0;
        if (count < gbn_pkg::BUF_DEPTH) begin
          backlog[(head + count) % gbn_pkg::BUF_DEPTH] = p;
          count++;
        end else begin
          drop = 1;
        end
        fill_window(q, 1);
        if (q.size() == 0) q.push_back(e);
        q[q.size()-1].drop = drop;
      end
      gbn_pkg::REQ_ACK: begin
        if (csum(s, a, p) == c && (a - base_seq) < outst) begin
          freed = a + 1 - base_seq;
          base_seq = a + 1;
          head = (head + freed) % gbn_pkg::BUF_DEPTH;
          count -= freed;
          fill_window(q, 0);
          if (q.size() == 0) q.push_back(e);
          q[q.size()-1].tmr = (base_seq == next_seq) ? gbn_pkg::TMR_STOP
                                                     : gbn_pkg::TMR_RESTART;
          q[q.size()-1].acc = 1;
        end else begin
          q.push_back(e);
        end
      end
      gbn_pkg::REQ_TMO: begin
        for (int unsigned i = 0; i < outst && i < 16; i++)
          q.push_back(pkt_beat(base_seq + i, backlog[(head + i) % gbn_pkg::BUF_DEPTH],
                               i == 0 ? gbn_pkg::TMR_START : gbn_pkg::TMR_NONE));
        if (q.size() == 0) begin
          e.tmr = gbn_pkg::TMR_START;
          q.push_back(e);
        end
      end
      default: q.push_back(e);
    endcase
    q[q.size()-1].fin = 1;
    if (use_exp) begin
      // Rows whose single empty result is obvious are checked against it directly.
      e = '{default: 0};
      e.tmr = etm;
      e.fin = 1;
      pending.push_back(e);
    end else begin
      foreach (q[i]) pending.push_back(q[i]);
    end
  endfunction

  always @(posedge clk) begin
    beat_t x;
    if (!rst && out_strobe) begin
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        failed = 1;
      end else begin
        x = pending.pop_front();
        if (pkt_valid !== x.pv) begin
          $error("pkt_valid exp %0h got %0h", x.pv, pkt_valid); failed = 1;
        end
        if (out_seqnum !== x.seq) begin
          $error("out_seqnum exp %0h got %0h", x.seq, out_seqnum); failed = 1;
        end
        if (out_payload_w0 !== x.w0) begin
          $error("out_payload_w0 exp %0h got %0h", x.w0, out_payload_w0); failed = 1;
        end
        if (out_payload_w1 !== x.w1) begin
          $error("out_payload_w1 exp %0h got %0h", x.w1, out_payload_w1); failed = 1;
        end
        if (out_payload_w2 !== x.w2) begin
          $error("out_payload_w2 exp %0h got %0h", x.w2, out_payload_w2); failed = 1;
        end
        if (out_checksum !== x.cs) begin
          $error("out_checksum exp %0h got %0h", x.cs, out_checksum); failed = 1;
        end
        if (timer_action !== x.tmr) begin
          $error("timer_action exp %0h got %0h", x.tmr, timer_action); failed = 1;
        end
        if (msg_dropped !== x.drop) begin
          $error("msg_dropped exp %0h got %0h", x.drop, msg_dropped); failed = 1;
        end
        if (ack_accepted !== x.acc) begin
          $error("ack_accepted exp %0h got %0h", x.acc, ack_accepted); failed = 1;
        end
        if (last !== x.fin) begin
          $error("last exp %0h got %0h", x.fin, last); failed = 1;
        end
      end
    end
  end

  // Presents one item, optionally after an idle gap, and waits until it is accepted.
  task automatic send_item(row_t r, int unsigned gap);
    logic [gbn_pkg::PAYLOAD_W-1:0] p;
    p = {r.w2, r.w1, r.w0};
    if (r.fix_cs) r.cs = csum(r.seq, r.ack, clean(p));
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    req_type <= r.kind;
    payload_w0 <= r.w0;
    payload_w1 <= r.w1;
    payload_w2 <= r.w2;
    pkt_seqnum <= r.seq;
    pkt_acknum <= r.ack;
    pkt_checksum <= r.cs;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_sender(r.kind, p, r.seq, r.ack, r.cs, r.has_exp, r.exp_tmr);
  endtask

  task automatic drain_and_config(logic [4:0] v);
    start <= 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    win_reg = v;
  endtask

  function automatic logic [gbn_pkg::PAYLOAD_W-1:0] rand_payload();
    logic [gbn_pkg::PAYLOAD_W-1:0] p;
    for (int i = 0; i < gbn_pkg::PAYLOAD_BYTES; i++)
      p[8*i +: 8] = ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom);
    return p;
  endfunction

  function automatic row_t rand_row(int unsigned pmsg);
    row_t r;
    logic [gbn_pkg::PAYLOAD_W-1:0] p;
    logic [31:0] outst;
    int unsigned pick;
    p = rand_payload();
    r = '{default: 0};
    r.w0 = p[63:0];
    r.w1 = p[127:64];
    r.w2 = p[159:128];
    r.seq = $urandom;
    r.ack = $urandom;
    r.cs = $urandom;
    outst = next_seq - base_seq;
    pick = $urandom_range(0, 99);
    if (pick < pmsg) begin
      r.kind = gbn_pkg::REQ_MSG;
    end else if (pick < pmsg + (100 - pmsg) * 6 / 10) begin
      r.kind = gbn_pkg::REQ_ACK;
      r.fix_cs = 1;
      if (outst > 0) r.ack = base_seq + $urandom_range(0, outst - 1);
    end else if (pick < 92) begin
      r.kind = gbn_pkg::REQ_TMO;
    end else begin
      case ($urandom_range(0, 2))
        0: r.kind = gbn_pkg::REQ_ACK;
        1: r.kind = 2'd3;
        default: begin
          r.kind = gbn_pkg::REQ_ACK;
          r.fix_cs = 1;
          r.ack = base_seq - 1;
        end
      endcase
    end
    return r;
  endfunction

  localparam int NDIR = 17;
  row_t dir_rows [NDIR] = '{
    '{gbn_pkg::REQ_TMO, 64'd0, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0, 0, 1, gbn_pkg::TMR_START},
    '{2'd3, '1, '1, '1, '1, '1, '1, 0, 1, gbn_pkg::TMR_NONE},
    '{gbn_pkg::REQ_ACK, 64'd0, 64'd0, 32'd0, 32'hffffffff, 32'd1, 32'd0, 0, 1,
      gbn_pkg::TMR_NONE},
    '{gbn_pkg::REQ_MSG, '1, '1, '1, 32'd0, 32'd0, 32'd0, 0, 0, gbn_pkg::TMR_NONE},
    '{gbn_pkg::REQ_MSG, 64'd0, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0, 0, 0, gbn_pkg::TMR_NONE},
    '{gbn_pkg::REQ_MSG, 64'h3736353433323130, 64'h4142004339383130, 32'h7f7f7f7f,
      32'd0, 32'd0, 32'd0, 0, 0, gbn_pkg::TMR_NONE},
    '{gbn_pkg::REQ_MSG, 64'h8080808080808080, 64'h7f7f7f7f7f7f7f7f, 32'h01020304,
      32'd0, 32'd0, 32'd0, 0, 0, gbn_pkg::TMR_NONE},
    '{gbn_pkg::REQ_TMO, 64'd0, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0, 0, 0, gbn_pkg::TMR_NONE},
    '{gbn_pkg::REQ_ACK, 64'h31, 64'd0, 32'd0, 32'd5, 32'd0, 32'd0, 1, 0, gbn_pkg::TMR_NONE},
    '{gbn_pkg::REQ_ACK, 64'h32, 64'd0, 32'd0, 32'd5, 32'd50, 32'd0, 1, 0,
      gbn_pkg::TMR_NONE},
    '{gbn_pkg::REQ_ACK, 64'h33, 64'd0, 32'd0, 32'd5, 32'd1, 32'd123, 0, 0,
      gbn_pkg::TMR_NONE},
    '{gbn_pkg::REQ_ACK, '1, '1, '1, 32'h80000000, 32'd2, 32'd0, 1, 0, gbn_pkg::TMR_NONE},
    '{gbn_pkg::REQ_MSG, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 32'h5555aaaa,
      32'd0, 32'd0, 32'd0, 0, 0, gbn_pkg::TMR_NONE},
    '{gbn_pkg::REQ_ACK, 64'd0, 64'd0, 32'd0, 32'h7fffffff, 32'd5, 32'd0, 1, 0,
      gbn_pkg::TMR_NONE},
    '{gbn_pkg::REQ_TMO, 64'd0, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0, 0, 1, gbn_pkg::TMR_START},
    '{gbn_pkg::REQ_MSG, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 32'haaaa5555,
      32'd0, 32'd0, 32'd0, 0, 0, gbn_pkg::TMR_NONE},
    '{gbn_pkg::REQ_ACK, 64'h0100, 64'd0, 32'd0, 32'd0, 32'd6, 32'd0, 1, 0,
      gbn_pkg::TMR_NONE}
  };

  localparam int NPH = 7;
  logic [4:0]  ph_win  [NPH] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd17, 5'd8};
  int unsigned ph_msg  [NPH] = '{85, 50, 45, 45, 40, 45, 45};
  int unsigned ph_idle [NPH] = '{12, 12, 82, 82, 82, 0, 0};

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (dir_rows[i]) send_item(dir_rows[i], $urandom_range(0, 1));
    for (int ph = 0; ph < NPH; ph++) begin
      drain_and_config(ph_win[ph]);
      for (int k = 0; k < 42; k++)
        send_item(rand_row(ph_msg[ph]),
                  ($urandom_range(0, 99) < ph_idle[ph]) ? $urandom_range(1, 25) : 0);
    end
    start <= 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (!failed)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
